// ----- hdl/rmq_pkg.sv -----
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared constants, widths and pipeline side-band types for the
// rotation matrix to quaternion converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // fixed point format of every matrix element and quaternion component
  localparam int FRAC_BITS = 14;
  localparam int ELEM_W    = 16;

  // first stage: branch sums and off-diagonal terms
  localparam int SUM_W   = 19;
  localparam int NUM_W   = 17;
  // magnitude of a sum of two most-negative elements needs all NUM_W bits
  localparam int MAG1_W  = NUM_W;

  // first square root: radicand sum << FRAC_BITS, padded to even width
  localparam int RAD1_W  = 32;
  localparam int ROOT1_W = RAD1_W / 2;
  localparam int S_W     = ROOT1_W + 1;
  localparam int QTR_W   = ROOT1_W - 1;

  // first divide: (mag << FRAC_BITS) / s, divisor s is at least 256
  localparam int DIV1_DW = MAG1_W + FRAC_BITS;
  localparam int QMAG_W  = 22;

  // norm: sum of four squares and its square root
  localparam int SQ_W    = 2 * QMAG_W;
  localparam int RAD2_W  = SQ_W + 2;
  localparam int NORM_W  = RAD2_W / 2;

  // second divide: (q << FRAC_BITS) / norm, result never above one
  localparam int DIV2_DW = QMAG_W + FRAC_BITS;
  localparam int OUT_QW  = FRAC_BITS + 1;

  // output saturation limit, min(one, 32767)
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int LIM_I = (ONE_I < 32767) ? ONE_I : 32767;
  localparam logic [OUT_QW-1:0] LIM = OUT_QW'(LIM_I);

  // selected branch of the method
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // side-band through the first square root
  typedef struct packed {
    branch_t                  sel;
    logic signed [NUM_W-1:0]  n0;
    logic signed [NUM_W-1:0]  n1;
    logic signed [NUM_W-1:0]  n2;
  } side1_t;

  // side-band through the first divider
  typedef struct packed {
    branch_t              sel;
    logic [2:0]           nneg;
    logic [QTR_W-1:0]     qtr;
    logic                 deg;
  } side2_t;

  // side-band through the norm square root
  typedef struct packed {
    logic [3:0][QMAG_W-1:0] qmag;
    logic [3:0]             qneg;
    logic                   deg;
  } side3_t;

  // side-band through the second divider
  typedef struct packed {
    logic [3:0] qneg;
    logic       deg;
  } side4_t;

endpackage

`default_nettype wire

// ----- hdl/rmq_sqrt_pipe.sv -----
// ---------------------------------------------------------------------------
// rmq_sqrt_pipe
// Pipelined integer square root, one result bit per register stage,
// with a side-band word carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_pipe #(
  parameter int RW = 32,
  parameter int SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_valid,
  input  wire logic [RW-1:0]     in_rad,
  input  wire logic [SW-1:0]     in_side,
  output logic                   out_valid,
  output logic [RW/2-1:0]        out_root,
  output logic [SW-1:0]          out_side
);

  localparam int N = RW / 2;

  logic [RW-1:0]  rad_q  [N];
  logic [N+1:0]   rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [SW-1:0]  side_q [N];
  logic           vld_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] p_rad;
    logic [N+1:0]  p_rem;
    logic [N-1:0]  p_root;
    logic [SW-1:0] p_side;
    logic          p_vld;
    logic [N+3:0]  rs;
    logic [N+3:0]  trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rad  = rad_q[k-1];
      assign p_rem  = rem_q[k-1];
      assign p_root = root_q[k-1];
      assign p_side = side_q[k-1];
      assign p_vld  = vld_q[k-1];
    end

    // bring down two radicand bits and try 4*root+1
    assign rs    = {p_rem, p_rad[RW-1:RW-2]};
    assign trial = (N+4)'({p_root, 2'b01});
    assign ge    = rs >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (ce) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rad_q[k]  <= {p_rad[RW-3:0], 2'b00};
        rem_q[k]  <= ge ? (N+2)'(rs - trial) : (N+2)'(rs);
        root_q[k] <= {p_root[N-2:0], ge};
        side_q[k] <= p_side;
      end
    end
  end

  assign out_valid = vld_q[N-1];
  assign out_root  = root_q[N-1];
  assign out_side  = side_q[N-1];

endmodule

`default_nettype wire

// ----- hdl/rmq_div_pipe.sv -----
// ---------------------------------------------------------------------------
// rmq_div_pipe
// Pipelined restoring divider, several dividends over one shared divisor,
// one quotient bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rmq_div_pipe #(
  parameter int LANES = 3,
  parameter int DW    = 30,
  parameter int VW    = 17,
  parameter int QW    = 22,
  parameter int SW    = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         ce,
  input  wire logic                         in_valid,
  input  wire logic [LANES-1:0][DW-1:0]     in_dividend,
  input  wire logic [VW-1:0]                in_divisor,
  input  wire logic [SW-1:0]                in_side,
  output logic                              out_valid,
  output logic [LANES-1:0][QW-1:0]          out_quot,
  output logic [SW-1:0]                     out_side
);

  // the quotient fits QW bits, so the dividend's upper part is below the divisor
  logic [LANES-1:0][VW-1:0] rem_q [QW];
  logic [LANES-1:0][QW-1:0] lo_q  [QW];
  logic [VW-1:0]            div_q [QW];
  logic [SW-1:0]            side_q[QW];
  logic                     vld_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LANES-1:0][VW-1:0] p_rem;
    logic [LANES-1:0][VW-1:0] n_rem;
    logic [LANES-1:0][QW-1:0] p_lo;
    logic [LANES-1:0][QW-1:0] n_lo;
    logic [VW-1:0]            p_div;
    logic [SW-1:0]            p_side;
    logic                     p_vld;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign p_rem[l] = VW'(in_dividend[l][DW-1:QW]);
        assign p_lo[l]  = in_dividend[l][QW-1:0];
      end
      assign p_div  = in_divisor;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_q[k-1];
      assign p_lo   = lo_q[k-1];
      assign p_div  = div_q[k-1];
      assign p_side = side_q[k-1];
      assign p_vld  = vld_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [VW:0] r2;
      logic        ge;
      assign r2       = {p_rem[l], p_lo[l][QW-1]};
      assign ge       = r2 >= {1'b0, p_div};
      assign n_rem[l] = ge ? VW'(r2 - {1'b0, p_div}) : VW'(r2);
      assign n_lo[l]  = {p_lo[l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (ce) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[k]  <= n_rem;
        lo_q[k]   <= n_lo;
        div_q[k]  <= p_div;
        side_q[k] <= p_side;
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign out_quot  = lo_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

`default_nettype wire

// ----- hdl/rotation_matrix_to_quaternion.sv -----
// Throughput: one matrix per cycle unless the output stalls; every stage is a
//   register stage with its own valid bit, and the two square roots and two
//   dividers each produce one result bit per stage.
// A stalled output freezes the whole pipeline; s_tready = !m_tvalid || m_tready.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd's method in fixed point: branch select, s = 2*sqrt(sum), divide
// off-diagonal terms by s, then normalize by the integer Euclidean norm.
// ---------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
  input  wire logic [143:0]  s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
  output logic [63:0]        m_tdata,
  // degenerate
  output logic               m_tuser
);

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(ONE_I);

  logic ce;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // input register
  logic                     a_vld;
  logic signed [ELEM_W-1:0] a_m [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (ce) begin
      a_vld <= s_tvalid;
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_in
    always_ff @(posedge clk) begin
      if (ce) begin
        a_m[i] <= s_tdata[i*ELEM_W +: ELEM_W];
      end
    end
  end

  // branch select, radicand and off-diagonal terms
  logic signed [SUM_W-1:0] tr, sum;
  logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  side1_t                  b_side_next;
  logic [RAD1_W-1:0]       b_rad_next;

  assign tr = SUM_W'(a_m[0]) + SUM_W'(a_m[4]) + SUM_W'(a_m[8]);
  assign d21_12 = NUM_W'(a_m[7]) - NUM_W'(a_m[5]);
  assign d02_20 = NUM_W'(a_m[2]) - NUM_W'(a_m[6]);
  assign d10_01 = NUM_W'(a_m[3]) - NUM_W'(a_m[1]);
  assign s01_10 = NUM_W'(a_m[1]) + NUM_W'(a_m[3]);
  assign s02_20 = NUM_W'(a_m[2]) + NUM_W'(a_m[6]);
  assign s12_21 = NUM_W'(a_m[5]) + NUM_W'(a_m[7]);

  always_comb begin
    if (tr > 0) begin
      b_side_next.sel = BR_TRACE;
      sum = ONE_S + tr;
      b_side_next.n0 = d21_12;
      b_side_next.n1 = d02_20;
      b_side_next.n2 = d10_01;
    end else if (a_m[0] > a_m[4] && a_m[0] > a_m[8]) begin
      b_side_next.sel = BR_X;
      sum = ONE_S + SUM_W'(a_m[0]) - SUM_W'(a_m[4]) - SUM_W'(a_m[8]);
      b_side_next.n0 = d21_12;
      b_side_next.n1 = s01_10;
      b_side_next.n2 = s02_20;
    end else if (a_m[4] > a_m[8]) begin
      b_side_next.sel = BR_Y;
      sum = ONE_S + SUM_W'(a_m[4]) - SUM_W'(a_m[0]) - SUM_W'(a_m[8]);
      b_side_next.n0 = d02_20;
      b_side_next.n1 = s01_10;
      b_side_next.n2 = s12_21;
    end else begin
      b_side_next.sel = BR_Z;
      sum = ONE_S + SUM_W'(a_m[8]) - SUM_W'(a_m[0]) - SUM_W'(a_m[4]);
      b_side_next.n0 = d10_01;
      b_side_next.n1 = s02_20;
      b_side_next.n2 = s12_21;
    end
    b_rad_next = (sum > 0) ? (RAD1_W'(sum) << FRAC_BITS) : '0;
  end

  logic              b_vld;
  logic [RAD1_W-1:0] b_rad;
  side1_t            b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (ce) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_rad  <= b_rad_next;
      b_side <= b_side_next;
    end
  end

  // s/2 = isqrt(sum << FRAC_BITS)
  logic                         r1_vld;
  logic [ROOT1_W-1:0]           r1_root;
  logic [$bits(side1_t)-1:0]    r1_side_raw;
  side1_t                       r1_side;

  rmq_sqrt_pipe #(
    .RW (RAD1_W),
    .SW ($bits(side1_t))
  ) u_sqrt_s (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (b_vld),
    .in_rad    (b_rad),
    .in_side   (b_side),
    .out_valid (r1_vld),
    .out_root  (r1_root),
    .out_side  (r1_side_raw)
  );

  assign r1_side = r1_side_raw;

  // magnitudes of the off-diagonal terms, scaled for the divide by s
  logic [S_W-1:0]   c_s_next;
  logic [MAG1_W-1:0] c_mag [3];
  logic [2:0]       c_neg;
  side2_t           c_side_next;

  assign c_s_next = {r1_root, 1'b0};
  assign c_neg    = {r1_side.n2[NUM_W-1], r1_side.n1[NUM_W-1], r1_side.n0[NUM_W-1]};
  assign c_mag[0] = MAG1_W'(r1_side.n0[NUM_W-1] ? -r1_side.n0 : r1_side.n0);
  assign c_mag[1] = MAG1_W'(r1_side.n1[NUM_W-1] ? -r1_side.n1 : r1_side.n1);
  assign c_mag[2] = MAG1_W'(r1_side.n2[NUM_W-1] ? -r1_side.n2 : r1_side.n2);

  assign c_side_next.sel  = r1_side.sel;
  assign c_side_next.nneg = c_neg;
  assign c_side_next.qtr  = r1_root[ROOT1_W-1:1];
  assign c_side_next.deg  = (r1_root == '0);

  logic                          c_vld;
  logic [2:0][DIV1_DW-1:0]       c_dvd;
  logic [S_W-1:0]                c_dvs;
  side2_t                        c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (ce) begin
      c_vld <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        c_dvd[i] <= {c_mag[i], {FRAC_BITS{1'b0}}};
      end
      c_dvs  <= c_side_next.deg ? S_W'(1) : c_s_next;
      c_side <= c_side_next;
    end
  end

  // off-diagonal terms divided by s
  logic                       v1_vld;
  logic [2:0][QMAG_W-1:0]     v1_quot;
  logic [$bits(side2_t)-1:0]  v1_side_raw;
  side2_t                     v1_side;

  rmq_div_pipe #(
    .LANES (3),
    .DW    (DIV1_DW),
    .VW    (S_W),
    .QW    (QMAG_W),
    .SW    ($bits(side2_t))
  ) u_div_s (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in_valid    (c_vld),
    .in_dividend (c_dvd),
    .in_divisor  (c_dvs),
    .in_side     (c_side),
    .out_valid   (v1_vld),
    .out_quot    (v1_quot),
    .out_side    (v1_side_raw)
  );

  assign v1_side = v1_side_raw;

  // place quarter-s and the quotients by branch
  logic [3:0][QMAG_W-1:0] d_mag_next;
  logic [3:0]             d_neg_next;
  logic [QMAG_W-1:0]      qtr_ext;

  assign qtr_ext = QMAG_W'(v1_side.qtr);

  always_comb begin
    unique case (v1_side.sel)
      BR_TRACE: begin
        d_mag_next = {v1_quot[2], v1_quot[1], v1_quot[0], qtr_ext};
        d_neg_next = {v1_side.nneg, 1'b0};
      end
      BR_X: begin
        d_mag_next = {v1_quot[2], v1_quot[1], qtr_ext, v1_quot[0]};
        d_neg_next = {v1_side.nneg[2:1], 1'b0, v1_side.nneg[0]};
      end
      BR_Y: begin
        d_mag_next = {v1_quot[2], qtr_ext, v1_quot[1], v1_quot[0]};
        d_neg_next = {v1_side.nneg[2], 1'b0, v1_side.nneg[1:0]};
      end
      default: begin
        d_mag_next = {qtr_ext, v1_quot[2], v1_quot[1], v1_quot[0]};
        d_neg_next = {1'b0, v1_side.nneg};
      end
    endcase
  end

  logic                   d_vld;
  logic [3:0][QMAG_W-1:0] d_mag;
  logic [3:0]             d_neg;
  logic                   d_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (ce) begin
      d_vld <= v1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_mag <= d_mag_next;
      d_neg <= d_neg_next;
      d_deg <= v1_side.deg;
    end
  end

  // squares of the four components
  logic                   e_vld;
  logic [SQ_W-1:0]        e_sq [4];
  side3_t                 e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (ce) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        e_sq[i] <= SQ_W'(d_mag[i]) * SQ_W'(d_mag[i]);
      end
      e_side.qmag <= d_mag;
      e_side.qneg <= d_neg;
      e_side.deg  <= d_deg;
    end
  end

  // sum of squares
  logic              f_vld;
  logic [RAD2_W-1:0] f_rad;
  side3_t            f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (ce) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_rad  <= RAD2_W'(e_sq[0]) + RAD2_W'(e_sq[1]) + RAD2_W'(e_sq[2])
              + RAD2_W'(e_sq[3]);
      f_side <= e_side;
    end
  end

  // norm = isqrt(sum of squares)
  logic                       r2_vld;
  logic [NORM_W-1:0]          r2_norm;
  logic [$bits(side3_t)-1:0]  r2_side_raw;
  side3_t                     r2_side;

  rmq_sqrt_pipe #(
    .RW (RAD2_W),
    .SW ($bits(side3_t))
  ) u_sqrt_norm (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_vld),
    .in_rad    (f_rad),
    .in_side   (f_side),
    .out_valid (r2_vld),
    .out_root  (r2_norm),
    .out_side  (r2_side_raw)
  );

  assign r2_side = r2_side_raw;

  // scale components for the divide by the norm
  logic                     g_vld;
  logic [3:0][DIV2_DW-1:0]  g_dvd;
  logic [NORM_W-1:0]        g_dvs;
  side4_t                   g_side;
  logic                     g_deg_next;

  assign g_deg_next = r2_side.deg || (r2_norm == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (ce) begin
      g_vld <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        g_dvd[i] <= {r2_side.qmag[i], {FRAC_BITS{1'b0}}};
      end
      g_dvs       <= g_deg_next ? NORM_W'(1) : r2_norm;
      g_side.qneg <= r2_side.qneg;
      g_side.deg  <= g_deg_next;
    end
  end

  // components divided by the norm
  logic                       v2_vld;
  logic [3:0][OUT_QW-1:0]     v2_quot;
  logic [$bits(side4_t)-1:0]  v2_side_raw;
  side4_t                     v2_side;

  rmq_div_pipe #(
    .LANES (4),
    .DW    (DIV2_DW),
    .VW    (NORM_W),
    .QW    (OUT_QW),
    .SW    ($bits(side4_t))
  ) u_div_norm (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .in_valid    (g_vld),
    .in_dividend (g_dvd),
    .in_divisor  (g_dvs),
    .in_side     (g_side),
    .out_valid   (v2_vld),
    .out_quot    (v2_quot),
    .out_side    (v2_side_raw)
  );

  assign v2_side = v2_side_raw;

  // saturate, restore sign, force zero when degenerate
  logic [3:0][ELEM_W-1:0] h_comp;

  always_comb begin
    logic [OUT_QW-1:0] c;
    for (int i = 0; i < 4; i++) begin
      c = (v2_quot[i] > LIM) ? LIM : v2_quot[i];
      if (v2_side.deg) begin
        h_comp[i] = '0;
      end else if (v2_side.qneg[i]) begin
        h_comp[i] = -ELEM_W'(c);
      end else begin
        h_comp[i] = ELEM_W'(c);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= v2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= h_comp;
      m_tuser <= v2_side.deg;
    end
  end

`ifndef SYNTHESIS
  // a degenerate result carries an all-zero quaternion
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result with nonzero quaternion");

  // quat_w stays within the saturation limit
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= $signed(17'(LIM_I)) &&
                  $signed(m_tdata[15:0]) >= -$signed(17'(LIM_I))))
    else $error("quat_w outside the saturation limit");

  // an accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> a_vld)
    else $error("accepted transaction lost at the input register");

  // a stall freezes the pipeline valid bits, checked at the d and g stages
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(d_vld) && $stable(g_vld))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_rotation_matrix_to_quaternion.sv -----
// ---------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives matrices into the converter over the input stream, predicts each
// quaternion with an exact integer model and checks every output
// transaction in order, with random idle bursts on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_rotation_matrix_to_quaternion
  import rmq_pkg::*;
();

  localparam int PIPE_LAT = 84;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
    logic               deg;
  } quat_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [143:0]  s_tdata;
  logic          m_tvalid;
  logic          m_tready;
  logic [63:0]   m_tdata;
  logic          m_tuser;

  quat_t quat_queue[$];
  int    err_count;
  bit    src_idle_en;
  bit    snk_idle_en;

  rotation_matrix_to_quaternion dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #30ms;
    $display("tb_rotation_matrix_to_quaternion: done, errors");
    $finish;
  end

  // exact integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // (num << FRAC_BITS) / den, truncated toward zero
  function automatic longint scaled_div(input longint num, input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag << FRAC_BITS) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // predicted quaternion for one matrix
  function automatic quat_t shepperd_quat(input logic [143:0] mat);
    longint m[9];
    longint sum, n0, n1, n2, q[4], lim, r;
    longint unsigned s, n2sum, norm, a;
    branch_t br;
    quat_t res;
    int k;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[16*i +: 16]));
    res = '0;
    if (m[0] + m[4] + m[8] > 0) begin
      br = BR_TRACE; sum = ONE_I + m[0] + m[4] + m[8];
      n0 = m[7] - m[5]; n1 = m[2] - m[6]; n2 = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br = BR_X; sum = ONE_I + m[0] - m[4] - m[8];
      n0 = m[7] - m[5]; n1 = m[1] + m[3]; n2 = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      br = BR_Y; sum = ONE_I + m[4] - m[0] - m[8];
      n0 = m[2] - m[6]; n1 = m[1] + m[3]; n2 = m[5] + m[7];
    end else begin
      br = BR_Z; sum = ONE_I + m[8] - m[0] - m[4];
      n0 = m[3] - m[1]; n1 = m[2] + m[6]; n2 = m[5] + m[7];
    end
    s = (sum > 0) ? 2 * int_sqrt(longint'(sum) << FRAC_BITS) : 0;
    if (s == 0) begin
      res.deg = 1'b1;
      return res;
    end
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == int'(br)) begin
        q[i] = s >> 2;
      end else begin
        q[i] = scaled_div((k == 0) ? n0 : (k == 1) ? n1 : n2, s);
        k++;
      end
    end
    n2sum = 0;
    for (int i = 0; i < 4; i++) begin
      a = (q[i] < 0) ? -q[i] : q[i];
      n2sum += a * a;
    end
    norm = int_sqrt(n2sum);
    if (norm == 0) begin
      res.deg = 1'b1;
      return res;
    end
    lim = LIM_I;
    for (int i = 0; i < 4; i++) begin
      r = scaled_div(q[i], norm);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      q[i] = r;
    end
    res.w = q[0][15:0]; res.x = q[1][15:0]; res.y = q[2][15:0]; res.z = q[3][15:0];
    return res;
  endfunction

  // send one matrix, with an optional idle burst before it
  task automatic send_matrix(input logic [143:0] mat);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    quat_queue.push_back(shepperd_quat(mat));
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'(-16384);
      1: return 16'd16384;
      2: return 16'($urandom_range(0, 32768) - 16384);
      3: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // random unit quaternion to matrix, small noise on each element
  function automatic logic [143:0] rand_rotation();
    real w, x, y, z, n;
    real e[9];
    logic [143:0] mat;
    w = $urandom_range(0, 2000) - 1000.0; x = $urandom_range(0, 2000) - 1000.0;
    y = $urandom_range(0, 2000) - 1000.0; z = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(w*w + x*x + y*y + z*z);
    if (n < 1.0) begin w = 1.0; n = 1.0; end
    w /= n; x /= n; y /= n; z /= n;
    e[0] = 1 - 2*(y*y + z*z); e[1] = 2*(x*y - w*z); e[2] = 2*(x*z + w*y);
    e[3] = 2*(x*y + w*z); e[4] = 1 - 2*(x*x + z*z); e[5] = 2*(y*z - w*x);
    e[6] = 2*(x*z - w*y); e[7] = 2*(y*z + w*x); e[8] = 1 - 2*(x*x + y*y);
    for (int i = 0; i < 9; i++)
      mat[16*i +: 16] = 16'($rtoi(e[i] * 16384.0) + int'($urandom_range(0, 4)) - 2);
    return mat;
  endfunction

  function automatic logic [143:0] diag_matrix(input int a, input int b, input int c);
    logic [143:0] mat;
    mat = '0;
    mat[15:0] = 16'(a); mat[79:64] = 16'(b); mat[143:128] = 16'(c);
    return mat;
  endfunction

  // output side: random stalls and in-order check
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected output transaction: %h %b", m_tdata, m_tuser);
        err_count++;
      end else begin
        want = quat_queue.pop_front();
        if (m_tdata[15:0] !== want.w) begin
          $error("quat_w: expected %0d, got %0d", want.w, $signed(m_tdata[15:0]));
          err_count++;
        end
        if (m_tdata[31:16] !== want.x) begin
          $error("quat_x: expected %0d, got %0d", want.x, $signed(m_tdata[31:16]));
          err_count++;
        end
        if (m_tdata[47:32] !== want.y) begin
          $error("quat_y: expected %0d, got %0d", want.y, $signed(m_tdata[47:32]));
          err_count++;
        end
        if (m_tdata[63:48] !== want.z) begin
          $error("quat_z: expected %0d, got %0d", want.z, $signed(m_tdata[63:48]));
          err_count++;
        end
        if (m_tuser !== want.deg) begin
          $error("degenerate: expected %0b, got %0b", want.deg, m_tuser);
          err_count++;
        end
      end
    end
  end

  // each branch, extremes and degenerate sums
  task automatic test_directed();
    logic [143:0] mat;
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    send_matrix('0);
    send_matrix(diag_matrix(-16384, -16384, -16384));
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(32767, 32767, 32767));
    send_matrix(diag_matrix(0, 0, 0) | {9{16'h0000}});
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'hffff}});
    send_matrix({9{16'h5555}});
    send_matrix({9{16'haaaa}});
    send_matrix(diag_matrix(5, 5, -20));
    send_matrix(diag_matrix(-16384, -16384, 16383));
    mat = diag_matrix(-32768, 0, 0);
    mat[31:16] = 16'h7fff; mat[47:32] = 16'h8000;
    send_matrix(mat);
    send_matrix(diag_matrix(-5000, -5000, -5000));
    send_matrix(diag_matrix(0, 16384, 16384));
    send_matrix(diag_matrix(-12000, 0, 0));
  endtask

  // mostly rotations, the rest arbitrary patterns
  task automatic test_random(input int count);
    logic [143:0] mat;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        mat = rand_rotation();
      end else begin
        for (int i = 0; i < 9; i++) mat[16*i +: 16] = rand_elem();
      end
      send_matrix(mat);
    end
  endtask

  // back to back with no idling
  task automatic test_streaming(input int count);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random(count);
  endtask

  initial begin
    int wait_cycles;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    err_count   = 0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(1300);
    test_streaming(230);
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (quat_queue.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_count == 0 && quat_queue.size() == 0) begin
      $display("tb_rotation_matrix_to_quaternion: done, clean");
    end else begin
      $display("tb_rotation_matrix_to_quaternion: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
